### sv/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// types, codes and constants shared by the wav stream pcm extractor
// ----------------------------------------------------------------------------
package wsp_pkg;

	localparam logic [31:0] TAG_RIFF    = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE    = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT     = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA    = 32'h6461_7461;
	localparam logic [31:0] FMT_MIN_LEN = 32'd16;
	localparam logic [7:0]  SAMPLE_BIAS = 8'h80;
	localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;
	localparam int          THIRD_SHIFT = 33;

	typedef enum logic [3:0] {
		PH_RIFF  = 4'd0,
		PH_RSIZE = 4'd1,
		PH_WAVE  = 4'd2,
		PH_ID    = 4'd3,
		PH_SIZE  = 4'd4,
		PH_FMT   = 4'd5,
		PH_SKIP  = 4'd6,
		PH_DATA  = 4'd7,
		PH_IDLE  = 4'd8,
		PH_COUNT = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FORMAT  = 2'd0,
		KIND_SAMPLE  = 2'd1,
		KIND_PARTIAL = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NOT_RIFF  = 3'd0,
		ERR_NOT_WAVE  = 3'd1,
		ERR_FMT_SHORT = 3'd2,
		ERR_BAD_WIDTH = 3'd3,
		ERR_NO_FMT    = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] sample_value;
		logic [15:0]        channel_count;
		logic [31:0]        rate_hz;
		logic [15:0]        sample_bits;
		logic [31:0]        sample_total;
		logic [2:0]         error_code;
		logic               last_of_data;
	} out_beat_t;

	typedef struct packed {
		logic       sof_clear;
		logic [3:0] idx;
		logic       tag_shift;
		logic       len_clear;
		logic       len_byte;
		logic       rem_load_fmt;
		logic       rem_load_len;
		logic       rem_dec;
		logic       fmt_byte;
		logic       fmt_set;
		logic       data_open;
		logic       data_step;
		logic       out_load;
		kind_t      out_kind;
		err_t       out_err;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic tag_riff;
		logic tag_wave;
		logic tag_fmt;
		logic tag_data;
		logic len_short;
		logic len_zero_next;
		logic len_zero;
		logic rem_zero;
		logic rem_one;
		logic fmt_known;
		logic width_ok;
		logic sample_done;
	} stat_t;

endpackage

### sv/wav_stream_pcm_extractor.sv
// ----------------------------------------------------------------------------
// wav_stream_pcm_extractor
// byte-stream wav parser emitting format, 16-bit pcm samples, partial samples and errors
// ----------------------------------------------------------------------------
// One file byte is taken per cycle. The single exception is the last byte of
// the data chunk header: after it the input is held off while the sample
// count is formed (a 32x32 reciprocal multiply for 3-byte samples) and the
// format or error beat is loaded. Results sit in one output register, so
// the next byte is taken in the same cycle that a waiting result is taken;
// while a result is stalled, input is stalled too. No clearing pass after reset.
module wav_stream_pcm_extractor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  wsp_pkg::in_beat_t  byte_beat,
	output logic               res_valid,
	input  logic               res_stall,
	output wsp_pkg::out_beat_t res_beat
);
	import wsp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	wsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.sof        (byte_beat.start_of_file),
		.byte_stall (byte_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	wsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_beat.data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.res_beat  (res_beat)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!res_valid || !res_stall))
		else $error("result register overwritten while stalled");

	a_data_open_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.data_open |-> (stat.fmt_known && stat.width_ok))
		else $error("data chunk started without a usable format");

	a_rem_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem_dec |-> !stat.rem_zero)
		else $error("remaining byte count wrapped");

	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.data_open |=> !cmd.data_open)
		else $error("data chunk started twice in a row");

endmodule

### sv/wsp_ctrl.sv
// ----------------------------------------------------------------------------
// wsp_ctrl
// parse state machine, header byte counter and handshake control
// ----------------------------------------------------------------------------
module wsp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	input  logic          sof,
	output logic          byte_stall,
	output logic          res_valid,
	input  logic          res_stall,
	input  wsp_pkg::stat_t stat,
	output wsp_pkg::cmd_t  cmd
);
	import wsp_pkg::*;

	phase_t     phase_q, phase_d, cur_phase;
	logic [3:0] hi_q, hi_d, cur_hi, hi_inc;
	logic       res_valid_q, res_valid_d;
	logic       slot_free, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RIFF;
			hi_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			hi_q        <= hi_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_comb begin
		cmd        = '0;
		phase_d    = phase_q;
		hi_d       = hi_q;
		slot_free  = !res_valid_q || !res_stall;
		byte_stall = (phase_q == PH_COUNT) || !slot_free;
		accept     = byte_valid && !byte_stall;
		cur_phase  = sof ? PH_RIFF : phase_q;
		cur_hi     = sof ? 4'd0 : hi_q;
		hi_inc     = cur_hi + 4'd1;
		cmd.idx    = cur_hi;
		if (accept) begin
			cmd.sof_clear = sof;
			phase_d = cur_phase;
			hi_d    = cur_hi;
			unique case (cur_phase)
				PH_RIFF, PH_WAVE, PH_ID: begin
					cmd.tag_shift = 1'b1;
					hi_d = hi_inc;
					if (cur_hi == 4'd3) begin
						hi_d = '0;
						if (cur_phase == PH_RIFF) begin
							if (!stat.tag_riff) begin
								cmd.out_load = 1'b1;
								cmd.out_kind = KIND_ERROR;
								cmd.out_err  = ERR_NOT_RIFF;
								phase_d      = PH_IDLE;
							end else begin
								phase_d = PH_RSIZE;
							end
						end else if (cur_phase == PH_WAVE) begin
							if (!stat.tag_wave) begin
								cmd.out_load = 1'b1;
								cmd.out_kind = KIND_ERROR;
								cmd.out_err  = ERR_NOT_WAVE;
								phase_d      = PH_IDLE;
							end else begin
								phase_d = PH_ID;
							end
						end else begin
							cmd.len_clear = 1'b1;
							phase_d = PH_SIZE;
						end
					end
				end
				PH_RSIZE: begin
					hi_d = hi_inc;
					if (cur_hi == 4'd3) begin
						hi_d    = '0;
						phase_d = PH_WAVE;
					end
				end
				PH_SIZE: begin
					cmd.len_byte = 1'b1;
					hi_d = hi_inc;
					if (cur_hi == 4'd3) begin
						hi_d = '0;
						if (stat.tag_fmt) begin
							if (stat.len_short) begin
								cmd.out_load = 1'b1;
								cmd.out_kind = KIND_ERROR;
								cmd.out_err  = ERR_FMT_SHORT;
								phase_d      = PH_IDLE;
							end else begin
								cmd.rem_load_fmt = 1'b1;
								phase_d = PH_FMT;
							end
						end else if (stat.tag_data) begin
							phase_d = PH_COUNT;
						end else begin
							cmd.rem_load_len = 1'b1;
							phase_d = stat.len_zero_next ? PH_ID : PH_SKIP;
						end
					end
				end
				PH_FMT: begin
					cmd.fmt_byte = 1'b1;
					if (cur_hi == 4'd15) begin
						hi_d        = '0;
						cmd.fmt_set = 1'b1;
						phase_d     = stat.rem_zero ? PH_ID : PH_SKIP;
					end else begin
						hi_d = hi_inc;
					end
				end
				PH_SKIP: begin
					cmd.rem_dec = 1'b1;
					if (stat.rem_one) begin
						hi_d    = '0;
						phase_d = PH_ID;
					end
				end
				PH_DATA: begin
					cmd.rem_dec   = 1'b1;
					cmd.data_step = 1'b1;
					if (stat.rem_one) begin
						phase_d = PH_IDLE;
					end
					if (stat.sample_done) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = KIND_SAMPLE;
						cmd.out_last = stat.rem_one;
					end else if (stat.rem_one) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = KIND_PARTIAL;
						cmd.out_last = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end else if (phase_q == PH_COUNT && slot_free) begin
			cmd.out_load = 1'b1;
			phase_d      = PH_IDLE;
			if (!stat.fmt_known) begin
				cmd.out_kind = KIND_ERROR;
				cmd.out_err  = ERR_NO_FMT;
			end else if (!stat.width_ok) begin
				cmd.out_kind = KIND_ERROR;
				cmd.out_err  = ERR_BAD_WIDTH;
			end else begin
				cmd.data_open = 1'b1;
				cmd.out_kind  = KIND_FORMAT;
				cmd.out_last  = stat.len_zero;
				phase_d       = stat.len_zero ? PH_IDLE : PH_DATA;
			end
		end
		if (cmd.out_load) begin
			res_valid_d = 1'b1;
		end else if (!res_stall) begin
			res_valid_d = 1'b0;
		end else begin
			res_valid_d = res_valid_q;
		end
	end

	assign res_valid = res_valid_q;

endmodule

### sv/wsp_dp.sv
// ----------------------------------------------------------------------------
// wsp_dp
// header fields, chunk counters, sample assembly and result register
// ----------------------------------------------------------------------------
module wsp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  wsp_pkg::cmd_t      cmd,
	output wsp_pkg::stat_t     stat,
	output wsp_pkg::out_beat_t res_beat
);
	import wsp_pkg::*;

	logic [31:0] tag_q, len_q, rem_q, rate_q;
	logic [15:0] chan_q, bits_q;
	logic        fmt_known_q;
	logic [23:0] asm_q, asm_next;
	logic [1:0]  sbi_q, sbi_next;
	logic [2:0]  width_q;
	out_beat_t   out_q, out_d;

	logic [31:0] tag_next, len_next, total;
	logic [12:0] width_full;
	logic [15:0] sample;
	logic [63:0] prod;

	always_comb begin
		tag_next   = {tag_q[23:0], data_byte};
		len_next   = len_q | ({24'd0, data_byte} << {cmd.idx[1:0], 3'b000});
		width_full = bits_q[15:3];
		sbi_next   = sbi_q + 2'd1;
		asm_next   = {data_byte, asm_q[23:8]};
		prod       = 64'(len_q) * 64'(THIRD_RECIP);

		stat.tag_riff      = (tag_next == TAG_RIFF);
		stat.tag_wave      = (tag_next == TAG_WAVE);
		stat.tag_fmt       = (tag_q == TAG_FMT);
		stat.tag_data      = (tag_q == TAG_DATA);
		stat.len_short     = (len_next < FMT_MIN_LEN);
		stat.len_zero_next = (len_next == '0);
		stat.len_zero      = (len_q == '0);
		stat.rem_zero      = (rem_q == '0);
		stat.rem_one       = (rem_q == 32'd1);
		stat.fmt_known     = fmt_known_q;
		stat.width_ok      = (width_full != '0) && (width_full <= 13'd4);
		stat.sample_done   = (sbi_next == width_q[1:0]);

		if (width_q == 3'd1) begin
			sample = {data_byte ^ SAMPLE_BIAS, 8'h00};
		end else begin
			sample = asm_next[23:8];
		end

		case (bits_q[5:3])
			3'd2:    total = {1'b0, len_q[31:1]};
			3'd3:    total = 32'(prod[63:THIRD_SHIFT]);
			3'd4:    total = {2'b00, len_q[31:2]};
			default: total = len_q;
		endcase

		out_d              = '0;
		out_d.kind         = cmd.out_kind;
		out_d.last_of_data = cmd.out_last;
		case (cmd.out_kind)
			KIND_SAMPLE: begin
				out_d.sample_value = sample;
			end
			KIND_FORMAT: begin
				out_d.channel_count = chan_q;
				out_d.rate_hz       = rate_q;
				out_d.sample_bits   = bits_q;
				out_d.sample_total  = total;
			end
			KIND_ERROR: begin
				out_d.error_code = cmd.out_err;
			end
			default: begin
				out_d.sample_value = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_known_q <= 1'b0;
		end else if (cmd.sof_clear) begin
			fmt_known_q <= 1'b0;
		end else if (cmd.fmt_set) begin
			fmt_known_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tag_shift) begin
			tag_q <= tag_next;
		end
		if (cmd.len_clear) begin
			len_q <= '0;
		end else if (cmd.len_byte) begin
			len_q <= len_next;
		end
		if (cmd.rem_load_fmt) begin
			rem_q <= len_next - FMT_MIN_LEN;
		end else if (cmd.rem_load_len) begin
			rem_q <= len_next;
		end else if (cmd.data_open) begin
			rem_q <= len_q;
		end else if (cmd.rem_dec) begin
			rem_q <= rem_q - 32'd1;
		end
		if (cmd.fmt_byte) begin
			case (cmd.idx)
				4'd2:    chan_q[7:0]   <= data_byte;
				4'd3:    chan_q[15:8]  <= data_byte;
				4'd4:    rate_q[7:0]   <= data_byte;
				4'd5:    rate_q[15:8]  <= data_byte;
				4'd6:    rate_q[23:16] <= data_byte;
				4'd7:    rate_q[31:24] <= data_byte;
				4'd14:   bits_q[7:0]   <= data_byte;
				4'd15:   bits_q[15:8]  <= data_byte;
				default: rate_q        <= rate_q;
			endcase
		end
		if (cmd.data_open) begin
			width_q <= bits_q[5:3];
			asm_q   <= '0;
			sbi_q   <= '0;
		end else if (cmd.data_step) begin
			if (stat.sample_done || stat.rem_one) begin
				asm_q <= '0;
				sbi_q <= '0;
			end else begin
				asm_q <= asm_next;
				sbi_q <= sbi_next;
			end
		end
		if (cmd.out_load) begin
			out_q <= out_d;
		end
	end

	assign res_beat = out_q;

endmodule
